### hdl/sfs_pkg.sv
// Shared types and constants for the sprite frame sequencer.
`timescale 1ns / 1ps
`default_nettype none

package sfs_pkg;

    // Table geometry
    localparam int MAX_STATES = 16;
    localparam int MAX_FRAMES = 32;
    localparam int ST_W       = 4;
    localparam int FR_W       = 5;
    localparam int CNT_W      = 6;
    localparam int TBL_DEPTH  = MAX_STATES * MAX_FRAMES;
    localparam int TBL_AW     = ST_W + FR_W;

    // Field widths
    localparam int ELAPSED_W = 16;
    localparam int COORD_W   = 16;
    localparam int PERIOD_W  = 20;
    localparam int ACC_W     = 21;   // period max plus one tick fits here

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(100000);

    // Configuration register indexes (paddr[2])
    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    // Animation modes
    localparam logic MODE_CYCLE     = 1'b0;
    localparam logic MODE_PING_PONG = 1'b1;

    // Operation codes carried in s_axis_tuser
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SELECT = 2'd1,
        OP_LOAD   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // Playback position that one advance step updates
    typedef struct packed {
        logic [FR_W-1:0] frame;
        logic            back;
    } t_pos;

endpackage

`default_nettype wire

### hdl/sfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/sfs_advance.sv
// One-frame advance step: cyclic wrap or ping-pong bounce.
`timescale 1ns / 1ps
`default_nettype none

module sfs_advance
    import sfs_pkg::*;
(
    input  wire              i_mode,
    input  wire [CNT_W-1:0]  i_count,
    input  wire t_pos        i_pos,
    output t_pos             o_pos
);

    logic [CNT_W-1:0] f_inc;
    logic [CNT_W-1:0] f_dec;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] cnt_m2;
    logic             at_end;

    assign f_inc  = {1'b0, i_pos.frame} + CNT_W'(1);
    assign f_dec  = {1'b0, i_pos.frame} - CNT_W'(1);
    assign cnt_m1 = i_count - CNT_W'(1);
    assign cnt_m2 = i_count - CNT_W'(2);
    assign at_end = (f_inc >= i_count);

    always_comb begin
        o_pos = i_pos;
        if (i_mode == MODE_CYCLE) begin
            o_pos.frame = at_end ? '0 : f_inc[FR_W-1:0];
        end else if (i_count == CNT_W'(1)) begin
            // single-frame state: parked at frame 0, direction untouched
            o_pos.frame = '0;
        end else if (!i_pos.back) begin
            if (at_end) begin
                o_pos.frame = cnt_m2[FR_W-1:0];
                o_pos.back  = 1'b1;
            end else begin
                o_pos.frame = f_inc[FR_W-1:0];
            end
        end else begin
            if (i_pos.frame == '0) begin
                o_pos.frame = FR_W'(1);
                o_pos.back  = 1'b0;
            end else if (f_dec >= i_count) begin
                // frame left beyond a shrunk count
                o_pos.frame = cnt_m1[FR_W-1:0];
            end else begin
                o_pos.frame = f_dec[FR_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

### hdl/sprite_frame_sequencer.sv
// Sprite animation frame sequencer: frame table, timebase and playback control.
//
//  Channel   | Direction | Signals                              | Contents
//  ----------+-----------+--------------------------------------+-------------------------
//  s_axis    | in        | tvalid, tready, tdata[63:0], tuser   | one command per transfer
//  m_axis    | out       | tvalid, tready, tdata[47:0], tuser   | one report per command
//  apb       | in        | psel, penable, pwrite, paddr[2:0]... | mode and frame period
//
//  Select, load and clear pass through their command state, a table read state
//  and a wait state; the report is registered as the sequencer returns to idle,
//  where the next command is taken. A tick first drains the time accumulator,
//  one frame period per cycle through a single subtract/compare unit, before
//  the same read and wait states. The frame table is a 512-entry RAM with
//  registered read, so each report spends a read state and a data state. Reset is
//  synchronous, active low; the table is not cleared. A new command is taken
//  while a report still waits on m_axis; the sequencer holds in its last step
//  if that report stalls.
`timescale 1ns / 1ps
`default_nettype none

module sprite_frame_sequencer
    import sfs_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // command stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] elapsed_us, [19:16] state_index, [24:20] frame_index,
    // [40:25] entry_x, [56:41] entry_y, [57] entry_is_final, [63:58] zero
    input  wire [63:0]  s_axis_tdata,
    // [1:0] operation
    input  wire [1:0]   s_axis_tuser,
    // report stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [15:0] frame_x, [31:16] frame_y, [35:32] current_state,
    // [40:36] current_frame, [47:41] zero
    output logic [47:0] m_axis_tdata,
    // [0] frame_changed, [1] request_rejected
    output logic [1:0]  m_axis_tuser,
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_SEL,
        S_LOAD,
        S_CLR,
        S_READ,
        S_WAIT
    } t_state;

    // ------------------------------------------------------------------
    // Configuration registers
    logic                r_mode;
    logic [PERIOD_W-1:0] r_period;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_CYCLE;
            r_period <= PERIOD_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MODE) begin
                r_mode <= pwdata[0];
            end else begin
                r_period <= pwdata[PERIOD_W-1:0];
            end
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MODE:   prdata = {31'd0, r_mode};
            REG_PERIOD: prdata = {{(32-PERIOD_W){1'b0}}, r_period};
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer registers
    t_state                r_state;
    logic [ST_W-1:0]       r_st;
    logic [FR_W-1:0]       r_fr;
    logic [COORD_W-1:0]    r_ex;
    logic [COORD_W-1:0]    r_ey;
    logic                  r_fin;
    logic [ST_W-1:0]       r_shown_state;
    t_pos                  r_pos;
    logic [ACC_W-1:0]      r_acc;
    logic                  r_changed;
    logic                  r_rejected;
    logic                  r_out_valid;
    logic [COORD_W-1:0]    r_out_x;
    logic [COORD_W-1:0]    r_out_y;
    logic [ST_W-1:0]       r_out_state;
    logic [FR_W-1:0]       r_out_frame;
    logic                  r_out_changed;
    logic                  r_out_rejected;

    logic [CNT_W-1:0]      r_fis [MAX_STATES];

    logic                  in_xfer;
    logic                  out_free;
    logic [PERIOD_W-1:0]   period_eff;
    logic [ST_W-1:0]       cnt_addr;
    logic [CNT_W-1:0]      count;
    logic                  acc_over;
    logic [ACC_W-1:0]      acc_sub;
    t_pos                  adv_pos;
    logic                  ram_we;
    logic                  ram_re;
    logic [2*COORD_W-1:0]  ram_rdata;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // zero period behaves as one microsecond
    assign period_eff = (r_period == '0) ? PERIOD_W'(1) : r_period;

    // frame count lookup: playing state during a tick, requested state otherwise
    assign cnt_addr = (r_state == S_TICK) ? r_shown_state : r_st;
    assign count    = r_fis[cnt_addr];

    // shared compare/subtract unit for draining the accumulator
    assign acc_over = (r_acc > ACC_W'(period_eff));
    assign acc_sub  = r_acc - ACC_W'(period_eff);

    sfs_advance u_adv (
        .i_mode  (r_mode),
        .i_count (count),
        .i_pos   (r_pos),
        .o_pos   (adv_pos)
    );

    // frame counts per state, written by loads marked final
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_STATES; i++) begin
                r_fis[i] <= '0;
            end
        end else if (r_state == S_LOAD && r_fin) begin
            r_fis[r_st] <= {1'b0, r_fr} + CNT_W'(1);
        end
    end

    // frame table
    assign ram_we = (r_state == S_LOAD);
    assign ram_re = (r_state == S_READ);

    sfs_ram #(
        .WIDTH (2*COORD_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr ({r_st, r_fr}),
        .i_wdata ({r_ey, r_ex}),
        .i_re    (ram_re),
        .i_raddr ({r_shown_state, r_pos.frame}),
        .o_rdata (ram_rdata)
    );

    // state machine, playback state and report register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_st           <= '0;
            r_fr           <= '0;
            r_ex           <= '0;
            r_ey           <= '0;
            r_fin          <= 1'b0;
            r_shown_state  <= '0;
            r_pos          <= '0;
            r_acc          <= '0;
            r_changed      <= 1'b0;
            r_rejected     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_out_x        <= '0;
            r_out_y        <= '0;
            r_out_state    <= '0;
            r_out_frame    <= '0;
            r_out_changed  <= 1'b0;
            r_out_rejected <= 1'b0;
        end else begin
            // report taken; in S_WAIT the next report replaces it below
            if (r_out_valid && m_axis_tready && r_state != S_WAIT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_st       <= s_axis_tdata[19:16];
                        r_fr       <= s_axis_tdata[24:20];
                        r_ex       <= s_axis_tdata[40:25];
                        r_ey       <= s_axis_tdata[56:41];
                        r_fin      <= s_axis_tdata[57];
                        r_changed  <= 1'b0;
                        r_rejected <= 1'b0;
                        unique case (t_op'(s_axis_tuser))
                            OP_TICK: begin
                                r_acc   <= r_acc + ACC_W'(s_axis_tdata[15:0]);
                                r_state <= S_TICK;
                            end
                            OP_SELECT: r_state <= S_SEL;
                            OP_LOAD:   r_state <= S_LOAD;
                            OP_CLEAR:  r_state <= S_CLR;
                            default:   r_state <= S_CLR;
                        endcase
                    end
                end
                S_TICK: begin
                    // one period per cycle until the accumulator is drained
                    if (acc_over) begin
                        r_acc <= acc_sub;
                        if (count != '0) begin
                            r_pos     <= adv_pos;
                            r_changed <= 1'b1;
                        end
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_SEL: begin
                    if ({1'b0, r_fr} < count) begin
                        r_shown_state <= r_st;
                        r_pos.frame   <= r_fr;
                        r_changed     <= 1'b1;
                    end else begin
                        r_rejected <= 1'b1;
                    end
                    r_state <= S_READ;
                end
                S_LOAD: begin
                    r_state <= S_READ;
                end
                S_CLR: begin
                    r_pos.back <= 1'b0;
                    r_state    <= S_READ;
                end
                S_READ: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_x        <= ram_rdata[COORD_W-1:0];
                        r_out_y        <= ram_rdata[2*COORD_W-1:COORD_W];
                        r_out_state    <= r_shown_state;
                        r_out_frame    <= r_pos.frame;
                        r_out_changed  <= r_changed;
                        r_out_rejected <= r_rejected;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // report stream
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_frame, r_out_state, r_out_y, r_out_x};
    assign m_axis_tuser  = {r_out_rejected, r_out_changed};

endmodule

`default_nettype wire
